// ----- rtl/midpoint_circle_rasterizer_top_defines.svh -----
// assertion macros for the midpoint circle rasterizer
// no dependencies; included by the top level only
`ifndef MIDPOINT_CIRCLE_RASTERIZER_TOP_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication under reset
`define MCR_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define MCR_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mcr_pkg.sv -----
// shared types and constants for the midpoint circle rasterizer
// no dependencies
`default_nettype none

package mcr_pkg;

	localparam int unsigned SCREEN_WIDTH  = 400;
	localparam int unsigned SCREEN_HEIGHT = 300;

	// input field widths
	localparam int unsigned OPW = 2;
	localparam int unsigned CRW = 12;
	// decision variable width
	localparam int unsigned DW = 16;
	// internal signed coordinate width, holds center +- radius and span ends
	localparam int unsigned CW = 15;
	// output field width
	localparam int unsigned SW = 9;
	// slot counter width
	localparam int unsigned SLW = 3;

	typedef enum logic [OPW-1:0] {
		OP_OUTLINE = 2'd0,
		OP_FILL    = 2'd1,
		OP_STEP    = 2'd2
	} op_t;

	typedef struct packed {
		logic [OPW-1:0]        opcode;
		logic signed [CRW-1:0] center_x;
		logic signed [CRW-1:0] center_y;
		logic signed [CRW-1:0] radius;
		logic                  pen_color;
	} item_t;

	// one pixel or span before clipping
	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] w;
	} point_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic res_valid;
		logic last;
		logic color;
		logic busy;
	} seq_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mcr_seq.sv -----
// circle sequencer: held circle state, slot selection and decision update
// depends on mcr_pkg
`default_nettype none

module mcr_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire mcr_pkg::item_t    item,
	output mcr_pkg::point_t        pt,
	output mcr_pkg::seq_stat_t     stat
);
	import mcr_pkg::*;

	logic                  busy_q;
	logic                  fill_q;
	logic signed [CRW-1:0] cx_q;
	logic signed [CRW-1:0] cy_q;
	logic signed [CRW-1:0] x_q;
	logic signed [CRW-1:0] y_q;
	logic signed [DW-1:0]  d_q;
	logic                  color_q;
	logic [SLW-1:0]        slot_q;

	logic signed [CW-1:0]  cxe, cye, xe, ye;
	logic                  is_start, is_step, wrap;
	logic signed [CRW:0]   x_nxt, y_nxt;
	logic signed [DW-1:0]  d_nxt;
	logic signed [DW-1:0]  xd, yd;

	assign cxe = CW'(cx_q);
	assign cye = CW'(cy_q);
	assign xe  = CW'(x_q);
	assign ye  = CW'(y_q);

	// mirrored point or span for the current slot
	always_comb begin
		pt = '0;
		if (!fill_q) begin
			pt.w = CW'(1);
			case (slot_q)
				3'd0: begin pt.px = cxe + xe; pt.py = cye + ye; end
				3'd1: begin pt.px = cxe - xe; pt.py = cye + ye; end
				3'd2: begin pt.px = cxe + xe; pt.py = cye - ye; end
				3'd3: begin pt.px = cxe - xe; pt.py = cye - ye; end
				3'd4: begin pt.px = cxe + ye; pt.py = cye + xe; end
				3'd5: begin pt.px = cxe - ye; pt.py = cye + xe; end
				3'd6: begin pt.px = cxe + ye; pt.py = cye - xe; end
				default: begin pt.px = cxe - ye; pt.py = cye - xe; end
			endcase
		end else begin
			case (slot_q[1:0])
				2'd0: begin
					pt.px = cxe - xe; pt.py = cye + ye; pt.w = (xe <<< 1) + CW'(1);
				end
				2'd1: begin
					pt.px = cxe - xe; pt.py = cye - ye; pt.w = (xe <<< 1) + CW'(1);
				end
				2'd2: begin
					pt.px = cxe - ye; pt.py = cye + xe; pt.w = (ye <<< 1) + CW'(1);
				end
				default: begin
					pt.px = cxe - ye; pt.py = cye - xe; pt.w = (ye <<< 1) + CW'(1);
				end
			endcase
		end
	end

	assign is_start = fire && (item.opcode == OP_OUTLINE || item.opcode == OP_FILL);
	assign is_step  = fire && (item.opcode == OP_STEP) && busy_q;
	assign wrap     = fill_q ? (slot_q[1:0] == 2'd3) : (slot_q == 3'd7);

	// end-of-iteration decision update
	assign xd = DW'(x_q);
	assign yd = DW'(y_q);
	always_comb begin
		x_nxt = (CRW+1)'(x_q) + (CRW+1)'(1);
		if (d_q < 0) begin
			d_nxt = d_q + (xd <<< 2) + DW'(6);
			y_nxt = (CRW+1)'(y_q);
		end else begin
			d_nxt = d_q + ((xd - yd) <<< 2) + DW'(10);
			y_nxt = (CRW+1)'(y_q) - (CRW+1)'(1);
		end
	end

	assign stat.res_valid = is_step;
	assign stat.last      = is_step && wrap && (x_nxt > y_nxt);
	assign stat.color     = color_q;
	assign stat.busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fill_q  <= 1'b0;
			cx_q    <= '0;
			cy_q    <= '0;
			x_q     <= '0;
			y_q     <= '0;
			d_q     <= '0;
			color_q <= 1'b0;
			slot_q  <= '0;
		end else if (is_start) begin
			busy_q  <= (item.radius > 0);
			fill_q  <= (item.opcode == OP_FILL);
			cx_q    <= item.center_x;
			cy_q    <= item.center_y;
			x_q     <= '0;
			y_q     <= item.radius;
			d_q     <= DW'(3) - (DW'(item.radius) <<< 1);
			color_q <= item.pen_color;
			slot_q  <= '0;
		end else if (is_step) begin
			if (wrap) begin
				slot_q <= '0;
				d_q    <= d_nxt;
				x_q    <= x_nxt[CRW-1:0];
				y_q    <= y_nxt[CRW-1:0];
				if (x_nxt > y_nxt) begin
					busy_q <= 1'b0;
				end
			end else begin
				slot_q <= slot_q + SLW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mcr_clip.sv -----
// screen clipping of one pixel or horizontal span
// depends on mcr_pkg
`default_nettype none

module mcr_clip (
	input  wire mcr_pkg::point_t         pt,
	output logic [mcr_pkg::SW-1:0]       span_x,
	output logic [mcr_pkg::SW-1:0]       span_y,
	output logic [mcr_pkg::SW-1:0]       span_length,
	output logic                         visible
);
	import mcr_pkg::*;

	localparam logic signed [CW-1:0] SCR_W = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] SCR_H = CW'(SCREEN_HEIGHT);

	logic signed [CW-1:0] x0, x1, x1c, len;
	logic                 row_ok;

	assign row_ok = (pt.py >= 0) && (pt.py < SCR_H);
	assign x0     = (pt.px < 0) ? '0 : pt.px;
	assign x1     = pt.px + pt.w;
	assign x1c    = (x1 > SCR_W) ? SCR_W : x1;
	assign len    = x1c - x0;

	assign visible     = row_ok && (x1c > x0);
	assign span_x      = visible ? x0[SW-1:0] : '0;
	assign span_y      = visible ? pt.py[SW-1:0] : '0;
	assign span_length = visible ? len[SW-1:0] : '0;

endmodule

`default_nettype wire

// ----- rtl/midpoint_circle_rasterizer_top.sv -----
// top level of the midpoint circle rasterizer: input register, sequencer,
// clipping and result register; depends on mcr_pkg, mcr_seq, mcr_clip
`default_nettype none

// Midpoint circle rasterizer. Send a start item (tuser 0 = outline, 1 = filled)
// carrying center, radius and pen color, then one step item per wanted result;
// each step while a circle runs returns one clipped pixel (outline, eight per
// iteration) or one clipped horizontal span (filled, four per iteration), and
// the final result of the circle has tlast set. Start items, steps while idle,
// opcode 3 and starts with radius zero or below return nothing. One item is
// accepted every clock while the output is not stalled; a step item waits in
// the input register until the result register can take its result, which is
// worked out combinationally by the sequencer and clip logic between the two
// registers and then offered on the output. Results off screen come back with
// tuser (visible) low and zero position and length.
`include "midpoint_circle_rasterizer_top_defines.svh"

module midpoint_circle_rasterizer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // center_x, center_y, radius, pen_color, zero fill
	input  wire logic [1:0]  s_tuser,  // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // span_x, span_y, span_length, pen_out, zero fill
	output logic             m_tuser,  // visible
	output logic             m_tlast   // last_item
);
	import mcr_pkg::*;

	// input stage
	logic      v_s1;
	item_t     item_s1;

	// result register
	logic          m_valid_q;
	logic [SW-1:0] sx_q, sy_q, len_q;
	logic          pen_q, vis_q, last_q;

	logic          out_ready, fire, in_acc;
	point_t        pt;
	seq_stat_t     stat;
	logic [SW-1:0] sx, sy, len;
	logic          vis;

	// result register frees when empty or being taken
	assign out_ready = !m_valid_q || m_tready;
	// held item is processed once the result side can take its result
	assign fire      = v_s1 && out_ready;
	assign s_tready  = !v_s1 || out_ready;
	assign in_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.opcode    <= s_tuser;
			item_s1.center_x  <= s_tdata[11:0];
			item_s1.center_y  <= s_tdata[23:12];
			item_s1.radius    <= s_tdata[35:24];
			item_s1.pen_color <= s_tdata[36];
		end
	end

	mcr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.pt     (pt),
		.stat   (stat)
	);

	mcr_clip u_clip (
		.pt          (pt),
		.span_x      (sx),
		.span_y      (sy),
		.span_length (len),
		.visible     (vis)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ready) begin
			m_valid_q <= stat.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && stat.res_valid) begin
			sx_q   <= sx;
			sy_q   <= sy;
			len_q  <= len;
			pen_q  <= stat.color;
			vis_q  <= vis;
			last_q <= stat.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, pen_q, len_q, sy_q, sx_q};
	assign m_tuser  = vis_q;
	assign m_tlast  = last_q;

	// an invisible result carries no position or length
	`MCR_ASSERT_NOW(a_invis_zero, clk, arst_n, m_valid_q && !vis_q,
		sx_q == '0 && sy_q == '0 && len_q == '0, "invisible result not zeroed")

	// a visible span is non-empty and ends on screen
	`MCR_ASSERT_NOW(a_vis_span, clk, arst_n, m_valid_q && vis_q,
		len_q != '0 && ({1'b0, sx_q} + {1'b0, len_q}) <= (SW+1)'(SCREEN_WIDTH),
		"visible span out of screen")

	// the last result of a circle leaves the sequencer idle
	`MCR_ASSERT_NEXT(a_last_idle, clk, arst_n, fire && stat.last,
		!stat.busy && m_valid_q && last_q, "circle still busy after last result")

endmodule

`default_nettype wire

// ----- verif/midpoint_circle_rasterizer_top_test.sv -----
// self-checking testbench for the midpoint circle rasterizer top level
// depends on mcr_pkg and midpoint_circle_rasterizer_top; a scoreboard class predicts every span
`timescale 1ns / 100ps

module midpoint_circle_rasterizer_top_test;
	import mcr_pkg::*;

	// opcode that the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SCR_W = int'(SCREEN_WIDTH);
	localparam int SCR_H = int'(SCREEN_HEIGHT);
	// receiver hold-off length, long enough to fill the pipeline
	localparam int HOLD_CYCLES = 120;
	// effective items per idle phase
	localparam int PHASE_ITEMS = 600;

	// one expected pixel or span as it leaves the block
	typedef struct packed {
		logic [8:0] span_x;
		logic [8:0] span_y;
		logic [8:0] span_length;
		logic       pen_out;
		logic       visible;
		logic       last_item;
	} span_t;

	// circle walker that tracks the block and queues the spans it must emit
	class span_predictor;
		bit                 busy;
		bit                 fill_mode;
		int                 cen_x;
		int                 cen_y;
		int                 walk_x;
		int                 walk_y;
		logic signed [15:0] decision;
		bit                 color;
		int                 slot;
		span_t              pending_spans[$];
		int                 errors;
		int                 spans_checked;
		int                 spans_visible;

		function new();
			busy = 0;
			fill_mode = 0;
			cen_x = 0;
			cen_y = 0;
			walk_x = 0;
			walk_y = 0;
			decision = '0;
			color = 0;
			slot = 0;
			errors = 0;
			spans_checked = 0;
			spans_visible = 0;
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		function int pending();
			return pending_spans.size();
		endfunction

		// advance the walker for one accepted input item
		function void note_item(logic [1:0] op, logic signed [11:0] cx_in,
				logic signed [11:0] cy_in, logic signed [11:0] r_in, logic pen);
			int px;
			int py;
			int w;
			int x0;
			int x1;
			int slots;
			span_t s;
			if (op == OP_OUTLINE || op == OP_FILL) begin
				cen_x = cx_in;
				cen_y = cy_in;
				color = pen;
				fill_mode = (op == OP_FILL);
				slot = 0;
				walk_x = 0;
				walk_y = r_in;
				decision = 16'(3 - 2 * int'(r_in));
				busy = (r_in > 0);
				return;
			end
			if (op != OP_STEP || !busy)
				return;
			w = 1;
			if (!fill_mode) begin
				slots = 8;
				case (slot)
					0: begin px = cen_x + walk_x; py = cen_y + walk_y; end
					1: begin px = cen_x - walk_x; py = cen_y + walk_y; end
					2: begin px = cen_x + walk_x; py = cen_y - walk_y; end
					3: begin px = cen_x - walk_x; py = cen_y - walk_y; end
					4: begin px = cen_x + walk_y; py = cen_y + walk_x; end
					5: begin px = cen_x - walk_y; py = cen_y + walk_x; end
					6: begin px = cen_x + walk_y; py = cen_y - walk_x; end
					default: begin px = cen_x - walk_y; py = cen_y - walk_x; end
				endcase
			end else begin
				slots = 4;
				case (slot)
					0: begin px = cen_x - walk_x; py = cen_y + walk_y; w = 2 * walk_x + 1; end
					1: begin px = cen_x - walk_x; py = cen_y - walk_y; w = 2 * walk_x + 1; end
					2: begin px = cen_x - walk_y; py = cen_y + walk_x; w = 2 * walk_y + 1; end
					default: begin
						px = cen_x - walk_y; py = cen_y - walk_x; w = 2 * walk_y + 1;
					end
				endcase
			end
			s = '0;
			s.pen_out = color;
			// clip columns to the screen, rows off screen are invisible
			if (py >= 0 && py < SCR_H) begin
				x0 = (px < 0) ? 0 : px;
				x1 = px + w;
				if (x1 > SCR_W)
					x1 = SCR_W;
				if (x1 > x0) begin
					s.visible = 1;
					s.span_x = 9'(x0);
					s.span_y = 9'(py);
					s.span_length = 9'(x1 - x0);
				end
			end
			slot++;
			if (slot >= slots) begin
				slot = 0;
				if (decision < 0) begin
					decision = 16'(int'(decision) + 4 * walk_x + 6);
				end else begin
					decision = 16'(int'(decision) + 4 * (walk_x - walk_y) + 10);
					walk_y--;
				end
				walk_x++;
				if (walk_x > walk_y) begin
					busy = 0;
					s.last_item = 1;
				end
			end
			pending_spans.push_back(s);
		endfunction

		task check_field(string name, int got, int want);
			if (got != want)
				report($sformatf("span %0d field %s got %0d expected %0d",
					spans_checked, name, got, want));
		endtask

		// compare one accepted result with the oldest expected span
		task check_span(logic [31:0] data, logic vis, logic last);
			span_t e;
			if (pending_spans.size() == 0) begin
				report($sformatf("result with nothing expected, tdata %h", data));
				return;
			end
			e = pending_spans.pop_front();
			check_field("span_x", data[8:0], e.span_x);
			check_field("span_y", data[17:9], e.span_y);
			check_field("span_length", data[26:18], e.span_length);
			check_field("pen_out", data[27], e.pen_out);
			check_field("visible", vis, e.visible);
			check_field("last_item", last, e.last_item);
			if (e.visible)
				spans_visible++;
			spans_checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // center_x, center_y, radius, pen_color, zero fill
	logic [1:0]  s_tuser;   // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // span_x, span_y, span_length, pen_out, zero fill
	logic        m_tuser;   // visible
	logic        m_tlast;   // last_item

	span_predictor pred = new();

	// idle percentages of the current phase
	int send_idle_pct;
	int recv_idle_pct;
	// set by the stimulus, taken and cleared by the receiver process
	bit hold_req;
	// items that change the block state or produce a span
	int effective_items;
	int circles_started;

	midpoint_circle_rasterizer_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// results are taken at the rising edge with pre-edge values
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pred.check_span(m_tdata, m_tuser, m_tlast);
	end

	// offer one item from a falling edge and hold it until accepted
	task automatic send_item(logic [1:0] op, logic signed [11:0] cx, logic signed [11:0] cy,
			logic signed [11:0] r, logic pen);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {3'b000, pen, r, cy, cx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred.note_item(op, cx, cy, r, pen);
	endtask

	// step item with junk payload, the block must not look at it
	task automatic send_step();
		send_item(OP_STEP, 12'($urandom), 12'($urandom), 12'($urandom), 1'($urandom));
	endtask

	// start a circle and step it until done or the step budget runs out
	task automatic run_circle(logic [1:0] op, logic signed [11:0] cx, logic signed [11:0] cy,
			logic signed [11:0] r, logic pen, int max_steps);
		int n;
		n = 0;
		send_item(op, cx, cy, r, pen);
		if (r > 0) begin
			effective_items++;
			circles_started++;
		end
		while (pred.busy && n < max_steps) begin
			send_step();
			effective_items++;
			n++;
		end
	endtask

	// sender stops and waits until every expected span has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (pred.pending() != 0)
			@(posedge clk);
	endtask

	// one random sequence, mostly well formed circles
	task automatic random_sequence();
		int kind;
		int pick;
		int budget;
		logic [1:0] op;
		logic signed [11:0] cx;
		logic signed [11:0] cy;
		logic signed [11:0] r;
		kind = $urandom_range(99);
		if (kind < 8) begin
			// noise: unused opcode, stray step, or a start that draws nothing
			pick = $urandom_range(2);
			if (pick == 0)
				send_item(OP_UNUSED, 12'($urandom), 12'($urandom), 12'($urandom), 1'($urandom));
			else if (pick == 1 && !pred.busy)
				send_step();
			else
				send_item(1'($urandom) ? OP_FILL : OP_OUTLINE, 12'($urandom), 12'($urandom),
					-12'(signed'($urandom_range(2048))), 1'($urandom));
			return;
		end
		op = 1'($urandom) ? OP_FILL : OP_OUTLINE;
		if ($urandom_range(99) < 80) begin
			cx = 12'(int'($urandom_range(500)) - 50);
			cy = 12'(int'($urandom_range(400)) - 50);
		end else begin
			cx = 12'($urandom);
			cy = 12'($urandom);
		end
		pick = $urandom_range(99);
		budget = 1 << 30;
		if (pick < 70) begin
			r = 12'($urandom_range(24, 1));
		end else if (pick < 90) begin
			r = 12'($urandom_range(120, 25));
		end else if (pick < 98) begin
			r = 12'($urandom);
			budget = 200;
		end else begin
			r = 12'sd2047;
			budget = 60;
		end
		// some circles are cut short by the next start
		if ($urandom_range(99) < 15)
			budget = $urandom_range(40, 1);
		run_circle(op, cx, cy, r, 1'($urandom), budget);
		if ($urandom_range(99) < 20) begin
			repeat ($urandom_range(3, 1))
				send_step();
		end
	endtask

	initial begin
		#3000000;
		$display("%0t ns: timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int phase_start;
		int waited;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = OP_STEP;
		hold_req = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		effective_items = 0;
		circles_started = 0;
		arst_n = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;

		// directed: ignored items first
		send_step();
		send_item(OP_UNUSED, 12'sd0, 12'sd0, 12'sd5, 1'b1);
		// smallest circle at the screen corner, outline
		run_circle(OP_OUTLINE, 12'sd0, 12'sd0, 12'sd1, 1'b1, 100);
		// radius zero and most negative draw nothing
		send_item(OP_FILL, 12'sd100, 12'sd100, 12'sd0, 1'b1);
		send_step();
		send_item(OP_OUTLINE, 12'sd2047, -12'sd2048, -12'sd2048, 1'b0);
		send_step();
		// filled circle on the far corner
		run_circle(OP_FILL, 12'sd399, 12'sd299, 12'sd2, 1'b0, 100);
		// largest radius at extreme centers, dropped by a start while busy
		run_circle(OP_OUTLINE, -12'sd2048, 12'sd2047, 12'sd2047, 1'b1, 3);
		run_circle(OP_FILL, 12'sd200, 12'sd150, 12'sd3, 1'b1, 100);
		drain();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 8; recv_idle_pct = 87; end
				1: begin send_idle_pct = 87; recv_idle_pct = 8; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			phase_start = effective_items;
			// long receiver hold-off while steps keep coming, then a full drain
			hold_req = 1;
			run_circle(OP_OUTLINE, 12'sd200, 12'sd150, 12'sd60, 1'($urandom), 1 << 30);
			drain();
			while (effective_items - phase_start < PHASE_ITEMS)
				random_sequence();
		end

		@(negedge clk);
		s_tvalid <= 0;
		waited = 0;
		while (pred.pending() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pred.pending() != 0)
			pred.report($sformatf("%0d expected spans never arrived", pred.pending()));

		$display("covered %0d items over %0d circles, outline and filled, with stalls",
			effective_items, circles_started);
		$display("checked %0d spans, %0d of them on screen", pred.spans_checked,
			pred.spans_visible);
		if (pred.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mcr_pkg.sv
rtl/mcr_seq.sv
rtl/mcr_clip.sv
rtl/midpoint_circle_rasterizer_top.sv
verif/midpoint_circle_rasterizer_top_test.sv
